@@ hw/rtl/ewf_pkg.sv @@
`default_nettype none

package ewf_pkg;

    localparam int CHANNELS   = 4;
    localparam int MAX_WINDOW = 4096;

    localparam int SMP_W   = 16;
    localparam int LEN_W   = 13;
    localparam int SQ_W    = 43;
    localparam int ABS_W   = 28;
    localparam int WL_W    = 28;
    localparam int RMS_W   = 16;
    localparam int MAV_W   = 16;
    localparam int STEP_W  = 6;

    localparam int DIV_STEPS  = SQ_W;
    localparam int SQRT_STEPS = (SQ_W + 1) / 2;

    localparam logic [LEN_W-1:0] RESET_WINDOW = LEN_W'(1000);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(2);
    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } ewf_state_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic first;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/emg_window_features_unit.sv @@
// emg_window_features_unit
// Four-channel windowed EMG features: RMS, mean absolute value, waveform length.
// Input channel: in_valid / in_stall with sample_ch0..sample_ch3; an item is taken
// when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with rms_chN, mav_chN, wl_chN; one result
// is emitted for each completed window of window_length items.
// Config channel: cfg_valid / cfg_ready / cfg_data writes window_length; cfg_ready is
// always high. Values below 2 act as 2, values above 4096 act as 4096.
// Each item inside a window is registered by the square stage and then added in
// the accumulate stage of each lane; in_stall stays high until that is done.
// The item that closes a window goes on from accumulation to the load state,
// the bit-serial division, the digit-serial square root, and a done state that
// moves the lane results into the output register.
// The output register is separate from the lanes, so new items are taken while a
// result waits; a window end while the previous result is still stalled holds
// the block until that result is taken.
// Reset clears the accumulators, the sample count and the output valid, and sets
// window_length to 1000.
`default_nettype none

module emg_window_features_unit
    import ewf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [SMP_W-1:0] sample_ch0,
    input  wire logic signed [SMP_W-1:0] sample_ch1,
    input  wire logic signed [SMP_W-1:0] sample_ch2,
    input  wire logic signed [SMP_W-1:0] sample_ch3,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [RMS_W-1:0]             rms_ch0,
    output logic [RMS_W-1:0]             rms_ch1,
    output logic [RMS_W-1:0]             rms_ch2,
    output logic [RMS_W-1:0]             rms_ch3,
    output logic [MAV_W-1:0]             mav_ch0,
    output logic [MAV_W-1:0]             mav_ch1,
    output logic [MAV_W-1:0]             mav_ch2,
    output logic [MAV_W-1:0]             mav_ch3,
    output logic [WL_W-1:0]              wl_ch0,
    output logic [WL_W-1:0]              wl_ch1,
    output logic [WL_W-1:0]              wl_ch2,
    output logic [WL_W-1:0]              wl_ch3,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [LEN_W-1:0]        cfg_data
);

    ewf_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               first_reg, first_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   window_length_reg;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   count_inc;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    lane_ctrl_t         ctrl;

    logic signed [SMP_W-1:0] samples [CHANNELS];
    logic [RMS_W-1:0]   lane_rms [CHANNELS];
    logic [MAV_W-1:0]   lane_mav [CHANNELS];
    logic [WL_W-1:0]    lane_wl  [CHANNELS];
    logic [RMS_W-1:0]   rms_reg  [CHANNELS];
    logic [MAV_W-1:0]   mav_reg  [CHANNELS];
    logic [WL_W-1:0]    wl_reg   [CHANNELS];

    assign samples[0] = sample_ch0;
    assign samples[1] = sample_ch1;
    assign samples[2] = sample_ch2;
    assign samples[3] = sample_ch3;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        ewf_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (samples[g]),
            .len    (len_reg),
            .rms    (lane_rms[g]),
            .mav    (lane_mav[g]),
            .wl     (lane_wl[g])
        );
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= RESET_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_length_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (window_length_reg < MIN_LEN)
        begin
            eff_len = MIN_LEN;
        end
        else if (window_length_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = window_length_reg;
        end
    end

    assign count_inc = count_reg + LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b0;
            len_reg       <= MIN_LEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        first_next = first_reg;
        len_next   = len_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        ctrl       = '0;
        ctrl.first = first_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    first_next   = (count_reg == '0);
                    state_next   = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ctrl.accum = 1'b1;
                if (count_inc >= eff_len)
                begin
                    count_next = '0;
                    len_next   = eff_len;
                    state_next = ST_LOAD;
                end
                else
                begin
                    count_next = count_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                ctrl.div_start = 1'b1;
                step_next      = '0;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                begin
                    ctrl.sqrt_start = 1'b1;
                end
                else
                begin
                    ctrl.sqrt_step = 1'b1;
                end
                if (step_reg == STEP_W'(SQRT_STEPS))
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // merge lane results into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rms_reg[i] <= lane_rms[i];
                mav_reg[i] <= lane_mav[i];
                wl_reg[i]  <= lane_wl[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_ch0   = rms_reg[0];
    assign rms_ch1   = rms_reg[1];
    assign rms_ch2   = rms_reg[2];
    assign rms_ch3   = rms_reg[3];
    assign mav_ch0   = mav_reg[0];
    assign mav_ch1   = mav_reg[1];
    assign mav_ch2   = mav_reg[2];
    assign mav_ch3   = mav_reg[3];
    assign wl_ch0    = wl_reg[0];
    assign wl_ch1    = wl_reg[1];
    assign wl_ch2    = wl_reg[2];
    assign wl_ch3    = wl_reg[3];

`ifndef ASSERT_OFF
    a_accept_goes_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_ACC))
        else $error("accepted item did not enter accumulate stage");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < MAX_LEN)
        else $error("sample count beyond maximum window");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

    a_load_not_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ewf_lane.sv @@
`default_nettype none

module ewf_lane
    import ewf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lane_ctrl_t              ctrl,
    input  wire logic signed [SMP_W-1:0] sample,
    input  wire logic [LEN_W-1:0]        len,
    output logic [RMS_W-1:0]             rms,
    output logic [MAV_W-1:0]             mav,
    output logic [WL_W-1:0]              wl
);

    localparam int AX_W   = SMP_W + 1;
    localparam int SQR_W  = 2 * SMP_W - 1;
    localparam int REM_W  = LEN_W + 1;
    localparam int RAD_W  = 2 * SQRT_STEPS;
    localparam int SREM_W = SQRT_STEPS + 2;

    // front stage
    logic [AX_W-1:0]        abs_val;
    logic [AX_W-1:0]        diff;
    logic [AX_W-1:0]        diff_abs;
    logic [2*AX_W-1:0]      prod;
    logic [AX_W-1:0]        abs_reg;
    logic [AX_W-1:0]        dabs_reg;
    logic [SQR_W-1:0]       sq_reg;
    logic signed [SMP_W-1:0] prev_reg;

    // accumulators
    logic [SQ_W-1:0]        sq_sum_reg;
    logic [ABS_W-1:0]       abs_sum_reg;
    logic [WL_W-1:0]        wl_sum_reg;

    // dividers and root
    logic [SQ_W-1:0]        sq_div_reg;
    logic [SQ_W-1:0]        abs_div_reg;
    logic [REM_W-1:0]       sq_rem_reg;
    logic [REM_W-1:0]       abs_rem_reg;
    logic [WL_W-1:0]        wl_out_reg;
    logic [REM_W-1:0]       sq_shift;
    logic [REM_W-1:0]       abs_shift;
    logic                   sq_qbit;
    logic                   abs_qbit;
    logic [RAD_W-1:0]       rad_reg;
    logic [SQRT_STEPS-1:0]  root_reg;
    logic [SREM_W-1:0]      srem_reg;
    logic [SREM_W+1:0]      srem_shift;
    logic [SREM_W+1:0]      trial;
    logic                   rbit;

    always_comb
    begin
        abs_val  = sample[SMP_W-1] ? (AX_W'(0) - {sample[SMP_W-1], sample})
                                   : {1'b0, sample};
        diff     = {sample[SMP_W-1], sample} - {prev_reg[SMP_W-1], prev_reg};
        diff_abs = diff[AX_W-1] ? (AX_W'(0) - diff) : diff;
        prod     = abs_val * abs_val;
    end

    always_comb
    begin
        sq_shift   = {sq_rem_reg[REM_W-2:0], sq_div_reg[SQ_W-1]};
        abs_shift  = {abs_rem_reg[REM_W-2:0], abs_div_reg[SQ_W-1]};
        sq_qbit    = (sq_shift >= {1'b0, len});
        abs_qbit   = (abs_shift >= {1'b0, len});
        srem_shift = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial      = {2'b00, root_reg, 2'b01};
        rbit       = (srem_shift >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            abs_reg  <= abs_val;
            dabs_reg <= diff_abs;
            sq_reg   <= prod[SQR_W-1:0];
            prev_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_sum_reg  <= '0;
            abs_sum_reg <= '0;
            wl_sum_reg  <= '0;
        end
        else if (ctrl.div_start)
        begin
            sq_sum_reg  <= '0;
            abs_sum_reg <= '0;
            wl_sum_reg  <= '0;
        end
        else if (ctrl.accum)
        begin
            sq_sum_reg  <= sq_sum_reg + SQ_W'(sq_reg);
            abs_sum_reg <= abs_sum_reg + ABS_W'(abs_reg);
            if (!ctrl.first)
            begin
                wl_sum_reg <= wl_sum_reg + WL_W'(dabs_reg);
            end
        end
    end

    // one quotient bit per cycle for both divisions
    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            sq_div_reg  <= sq_sum_reg;
            abs_div_reg <= SQ_W'(abs_sum_reg);
            sq_rem_reg  <= '0;
            abs_rem_reg <= '0;
            wl_out_reg  <= wl_sum_reg;
        end
        else if (ctrl.div_step)
        begin
            sq_div_reg  <= {sq_div_reg[SQ_W-2:0], sq_qbit};
            abs_div_reg <= {abs_div_reg[SQ_W-2:0], abs_qbit};
            sq_rem_reg  <= sq_qbit ? (sq_shift - {1'b0, len}) : sq_shift;
            abs_rem_reg <= abs_qbit ? (abs_shift - {1'b0, len}) : abs_shift;
        end
    end

    // two radicand bits per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.sqrt_start)
        begin
            rad_reg  <= RAD_W'(sq_div_reg);
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (ctrl.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[SQRT_STEPS-2:0], rbit};
            srem_reg <= rbit ? SREM_W'(srem_shift - trial) : SREM_W'(srem_shift);
        end
    end

    assign rms = root_reg[RMS_W-1:0];
    assign mav = abs_div_reg[MAV_W-1:0];
    assign wl  = wl_out_reg;

endmodule

`default_nettype wire
